// File: rtl/core/dlm_pkg.sv
// Shared types and constants for the detection lag monitor.
// No dependencies; imported by detection_lag_monitor.
`default_nettype none

package dlm_pkg;

    localparam int LOGLIK_W   = 32;
    localparam int REGIME_W   = 8;
    localparam int IN_TDATA_W = 40;
    localparam int MEAN_W     = 32;
    localparam int VAR_W      = 48;
    localparam int LAG_W      = 5;
    localparam int VIOL_W     = 16;
    localparam int AVG_W      = 13;
    localparam int AVG_FRAC   = 8;
    localparam int DIV_CNT_W  = $clog2(AVG_W);
    localparam int LAG_TOP    = 31;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DROP_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAG_LIMIT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_TIMEOUT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_ALPHA     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_ALPHA     = 3'd4;

    localparam logic [15:0]      RST_DROP_THRESHOLD = 16'd512;
    localparam logic [LAG_W-1:0] RST_LAG_LIMIT      = 5'd5;
    localparam logic [LAG_W-1:0] RST_DROP_TIMEOUT   = 5'd20;
    localparam logic [15:0]      RST_FAST_ALPHA     = 16'd6554;
    localparam logic [15:0]      RST_SLOW_ALPHA     = 16'd1311;

    // 0.1 in unsigned Q32.16
    localparam logic [VAR_W-1:0] VAR_SEED = 48'd6554;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEV,
        ST_MSQ,
        ST_MALPHA,
        ST_MEAN,
        ST_VLO,
        ST_VHI,
        ST_VAR,
        ST_SURP,
        ST_THR,
        ST_TLO,
        ST_THI,
        ST_CMP,
        ST_DIV,
        ST_DONE
    } dlm_state_t;

endpackage

`default_nettype wire

// File: rtl/core/dlm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/detection_lag_monitor.sv
// Detection lag monitor top level: EMA tracking, drop detection, lag statistics.
// Depends on dlm_pkg and dlm_ram.
//
// One word in, one word out. The block takes a word, works on it alone and is
// not ready again until the result has gone to the output register. The first
// word after reset or after a regime change takes a shorter path (mean and
// variance reseed, no EMA passes), and a word that records a lag also runs
// the divider. The work is serialized through the single 32x32 multiplier,
// which runs the square, the two EMA products, the surprise square and the
// threshold-times-variance products one after another, and through the
// one-bit-per-cycle divider that forms the average lag. A result held in the
// output register does not block the next input word; a second finished
// result waits until the first is taken. Configuration writes are taken every
// cycle and must only happen while the block is idle.
`default_nettype none

module detection_lag_monitor
    import dlm_pkg::*;
#(
    parameter int HIST_DEPTH = 16,
    localparam int FILL_W      = $clog2(HIST_DEPTH + 1),
    localparam int OUT_W       = 42 + FILL_W,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // config write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // log_lik[31:0], regime[39:32]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // output stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // drop_active[0], regime_changed[1], lag_recorded[2], lag_value[7:3],
    // max_lag[12:8], violation_count[28:13], avg_lag[41:29],
    // history_fill[41+FILL_W:42], zero pad above
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int POS_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int SUM_W = $clog2(LAG_TOP * HIST_DEPTH + 1);
    localparam int AVG_INT = AVG_W - AVG_FRAC;

    // control state
    dlm_state_t              state_reg, state_next;
    logic                    fresh_reg, fresh_next;
    logic                    drop_reg, drop_next;
    logic [LAG_W-1:0]        ticks_reg, ticks_next;
    logic [REGIME_W-1:0]     prev_reg, prev_next;
    logic                    have_reg, have_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [LAG_W-1:0]        max_reg, max_next;
    logic [VIOL_W-1:0]       viol_reg, viol_next;
    logic [AVG_W-1:0]        avg_reg, avg_next;
    logic [DIV_CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic                    out_valid_reg, out_valid_next;

    // config
    logic [15:0]             thr_reg, thr_next;
    logic [LAG_W-1:0]        limit_reg, limit_next;
    logic [LAG_W-1:0]        timeout_reg, timeout_next;
    logic [15:0]             fast_reg, fast_next;
    logic [15:0]             slow_reg, slow_next;

    // datapath
    logic signed [LOGLIK_W-1:0] x_reg, x_next;
    logic [REGIME_W-1:0]     rin_reg, rin_next;
    logic signed [MEAN_W-1:0] mean_reg, mean_next;
    logic [VAR_W-1:0]        var_reg, var_next;
    logic [31:0]             ad_reg, ad_next;
    logic                    dneg_reg, dneg_next;
    logic [VAR_W-1:0]        sq_reg, sq_next;
    logic [VAR_W-1:0]        diff_reg, diff_next;
    logic                    vup_reg, vup_next;
    logic [63:0]             prod_reg, prod_next;
    logic [63:0]             acc_reg, acc_next;
    logic [63:0]             s2_reg, s2_next;
    logic [31:0]             thr2_reg, thr2_next;
    logic                    spos_reg, spos_next;
    logic [FILL_W-1:0]       rem_reg, rem_next;
    logic [AVG_W-1:0]        dvd_reg, dvd_next;
    logic                    res_chg_reg, res_chg_next;
    logic                    res_rec_reg, res_rec_next;
    logic [LAG_W-1:0]        res_lag_reg, res_lag_next;
    logic                    res_drop_reg, res_drop_next;
    logic [OUT_TDATA_W-1:0]  out_data_reg, out_data_next;

    // shared multiplier operands
    logic [31:0]             mul_a, mul_b;

    // scratch
    logic signed [MEAN_W:0]  dev;
    logic [MEAN_W:0]         dev_mag;
    logic signed [MEAN_W:0]  surp;
    logic [MEAN_W:0]         mean_sum;
    logic [VAR_W-1:0]        vstep;
    logic [64:0]             lim_sum;
    logic [63:0]             limit;
    logic                    lim_sat;
    logic                    trip;
    logic                    drop_tmp;
    logic [LAG_W-1:0]        ticks_tmp;
    logic                    chg;
    logic                    full;
    logic [FILL_W:0]         div_t;
    logic                    div_ge;

    // ring memory
    logic                    ram_we;
    logic [LAG_W-1:0]        ram_rdata;

    dlm_ram #(
        .WIDTH (LAG_W),
        .DEPTH (HIST_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (ticks_tmp),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MSQ:
            begin
                mul_a = ad_reg;
                mul_b = ad_reg;
            end
            ST_MALPHA:
            begin
                mul_a = ad_reg;
                mul_b = {16'b0, fast_reg};
            end
            ST_VLO:
            begin
                mul_a = diff_reg[31:0];
                mul_b = {16'b0, slow_reg};
            end
            ST_VHI:
            begin
                mul_a = {16'b0, diff_reg[47:32]};
                mul_b = {16'b0, slow_reg};
            end
            ST_SURP:
            begin
                mul_a = surp[31:0];
                mul_b = surp[31:0];
            end
            ST_THR:
            begin
                mul_a = {16'b0, thr_reg};
                mul_b = {16'b0, thr_reg};
            end
            ST_TLO:
            begin
                mul_a = prod_reg[31:0];
                mul_b = var_reg[31:0];
            end
            ST_THI:
            begin
                mul_a = thr2_reg;
                mul_b = {16'b0, var_reg[47:32]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // sequencer and state update
    always_comb
    begin
        state_next     = state_reg;
        fresh_next     = fresh_reg;
        drop_next      = drop_reg;
        ticks_next     = ticks_reg;
        prev_next      = prev_reg;
        have_next      = have_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        max_next       = max_reg;
        viol_next      = viol_reg;
        avg_next       = avg_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        thr_next       = thr_reg;
        limit_next     = limit_reg;
        timeout_next   = timeout_reg;
        fast_next      = fast_reg;
        slow_next      = slow_reg;
        x_next         = x_reg;
        rin_next       = rin_reg;
        mean_next      = mean_reg;
        var_next       = var_reg;
        ad_next        = ad_reg;
        dneg_next      = dneg_reg;
        sq_next        = sq_reg;
        diff_next      = diff_reg;
        vup_next       = vup_reg;
        acc_next       = acc_reg;
        s2_next        = s2_reg;
        thr2_next      = thr2_reg;
        spos_next      = spos_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        res_chg_next   = res_chg_reg;
        res_rec_next   = res_rec_reg;
        res_lag_next   = res_lag_reg;
        res_drop_next  = res_drop_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;

        dev      = {x_reg[LOGLIK_W-1], x_reg} - {mean_reg[MEAN_W-1], mean_reg};
        dev_mag  = dev[MEAN_W] ? (MEAN_W+1)'(-dev) : dev;
        surp     = {mean_reg[MEAN_W-1], mean_reg} - {x_reg[LOGLIK_W-1], x_reg};
        mean_sum = dneg_reg ?
                   {mean_reg[MEAN_W-1], mean_reg} - {1'b0, prod_reg[47:16]} :
                   {mean_reg[MEAN_W-1], mean_reg} + {1'b0, prod_reg[47:16]};
        vstep    = {prod_reg[31:0], 16'b0} + {16'b0, acc_reg[47:16]};
        lim_sum  = {1'b0, prod_reg[31:0], 32'b0} + {1'b0, acc_reg};
        lim_sat  = (prod_reg[63:32] != 32'b0) || lim_sum[64];
        limit    = lim_sat ? '1 : lim_sum[63:0];
        trip     = spos_reg && !drop_reg && (s2_reg > limit);
        drop_tmp = drop_reg || trip;
        ticks_tmp = trip ? '0 : ticks_reg;
        if (drop_tmp && ticks_tmp != LAG_W'(LAG_TOP))
        begin
            ticks_tmp = ticks_tmp + 1'b1;
        end
        chg      = have_reg && (rin_reg != prev_reg);
        full     = (fill_reg == FILL_W'(HIST_DEPTH));
        div_t    = {rem_reg, dvd_reg[AVG_W-1]};
        div_ge   = (div_t >= {1'b0, fill_reg});

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DROP_THRESHOLD: thr_next     = cfg_data;
                REG_LAG_LIMIT:      limit_next   = cfg_data[LAG_W-1:0];
                REG_DROP_TIMEOUT:   timeout_next = cfg_data[LAG_W-1:0];
                REG_FAST_ALPHA:     fast_next    = cfg_data;
                REG_SLOW_ALPHA:     slow_next    = cfg_data;
                default:            ;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    x_next     = s_axis_tdata[LOGLIK_W-1:0];
                    rin_next   = s_axis_tdata[LOGLIK_W +: REGIME_W];
                    state_next = ST_DEV;
                end
            end
            ST_DEV:
            begin
                if (fresh_reg)
                begin
                    mean_next  = x_reg;
                    var_next   = VAR_SEED;
                    state_next = ST_SURP;
                end
                else
                begin
                    ad_next    = dev_mag[31:0];
                    dneg_next  = dev[MEAN_W];
                    state_next = ST_MSQ;
                end
            end
            ST_MSQ:
            begin
                state_next = ST_MALPHA;
            end
            ST_MALPHA:
            begin
                sq_next    = prod_reg[63:16];
                state_next = ST_MEAN;
            end
            ST_MEAN:
            begin
                mean_next  = mean_sum[MEAN_W-1:0];
                vup_next   = (sq_reg >= var_reg);
                diff_next  = (sq_reg >= var_reg) ? sq_reg - var_reg : var_reg - sq_reg;
                state_next = ST_VLO;
            end
            ST_VLO:
            begin
                state_next = ST_VHI;
            end
            ST_VHI:
            begin
                acc_next   = prod_reg;
                state_next = ST_VAR;
            end
            ST_VAR:
            begin
                var_next   = vup_reg ? var_reg + vstep : var_reg - vstep;
                state_next = ST_SURP;
            end
            ST_SURP:
            begin
                spos_next  = !surp[MEAN_W] && (surp != '0);
                state_next = ST_THR;
            end
            ST_THR:
            begin
                s2_next    = prod_reg;
                state_next = ST_TLO;
            end
            ST_TLO:
            begin
                thr2_next  = prod_reg[31:0];
                state_next = ST_THI;
            end
            ST_THI:
            begin
                acc_next   = prod_reg;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                res_chg_next = chg;
                res_rec_next = chg && drop_tmp;
                res_lag_next = '0;
                state_next   = ST_DONE;
                if (chg && drop_tmp)
                begin
                    ram_we       = 1'b1;
                    res_lag_next = ticks_tmp;
                    sum_next     = sum_reg - (full ? SUM_W'(ram_rdata) : '0)
                                   + SUM_W'(ticks_tmp);
                    fill_next    = full ? fill_reg : fill_reg + 1'b1;
                    pos_next     = (pos_reg == POS_W'(HIST_DEPTH - 1)) ?
                                   '0 : pos_reg + 1'b1;
                    if (ticks_tmp > max_reg)
                    begin
                        max_next = ticks_tmp;
                    end
                    if (ticks_tmp > limit_reg && viol_reg != '1)
                    begin
                        viol_next = viol_reg + 1'b1;
                    end
                    // quotient fits AVG_W bits, so the top dividend bits seed the remainder
                    rem_next     = FILL_W'(sum_next >> AVG_INT);
                    dvd_next     = {sum_next[AVG_INT-1:0], {AVG_FRAC{1'b0}}};
                    div_cnt_next = '0;
                    drop_tmp     = 1'b0;
                    state_next   = ST_DIV;
                end
                fresh_next = chg;
                prev_next  = rin_reg;
                have_next  = 1'b1;
                if (drop_tmp && ticks_tmp > timeout_reg)
                begin
                    drop_tmp = 1'b0;
                end
                drop_next     = drop_tmp;
                ticks_next    = ticks_tmp;
                res_drop_next = drop_tmp;
            end
            ST_DIV:
            begin
                rem_next     = div_ge ? FILL_W'(div_t - {1'b0, fill_reg}) : div_t[FILL_W-1:0];
                dvd_next     = {dvd_reg[AVG_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(AVG_W - 1))
                begin
                    avg_next   = {dvd_reg[AVG_W-2:0], div_ge};
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = OUT_TDATA_W'({fill_reg, avg_reg, viol_reg, max_reg,
                                                   res_lag_reg, res_rec_reg, res_chg_reg,
                                                   res_drop_reg});
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg     <= 1'b1;
            drop_reg      <= 1'b0;
            ticks_reg     <= '0;
            prev_reg      <= '0;
            have_reg      <= 1'b0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            max_reg       <= '0;
            viol_reg      <= '0;
            avg_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            thr_reg       <= RST_DROP_THRESHOLD;
            limit_reg     <= RST_LAG_LIMIT;
            timeout_reg   <= RST_DROP_TIMEOUT;
            fast_reg      <= RST_FAST_ALPHA;
            slow_reg      <= RST_SLOW_ALPHA;
        end
        else
        begin
            fresh_reg     <= fresh_next;
            drop_reg      <= drop_next;
            ticks_reg     <= ticks_next;
            prev_reg      <= prev_next;
            have_reg      <= have_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            max_reg       <= max_next;
            viol_reg      <= viol_next;
            avg_reg       <= avg_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
            thr_reg       <= thr_next;
            limit_reg     <= limit_next;
            timeout_reg   <= timeout_next;
            fast_reg      <= fast_next;
            slow_reg      <= slow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        rin_reg      <= rin_next;
        mean_reg     <= mean_next;
        var_reg      <= var_next;
        ad_reg       <= ad_next;
        dneg_reg     <= dneg_next;
        sq_reg       <= sq_next;
        diff_reg     <= diff_next;
        vup_reg      <= vup_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        s2_reg       <= s2_next;
        thr2_reg     <= thr2_next;
        spos_reg     <= spos_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        res_chg_reg  <= res_chg_next;
        res_rec_reg  <= res_rec_next;
        res_lag_reg  <= res_lag_next;
        res_drop_reg <= res_drop_next;
        out_data_reg <= out_data_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(HIST_DEPTH))
        else $error("history fill above ring depth");

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_W'(LAG_TOP * fill_reg))
        else $error("ring sum exceeds largest possible lag total");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready again right after accepting a word");

    a_record_divides: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP && chg && drop_tmp == 1'b0 && ram_we) |=>
        (state_reg == ST_DIV && fill_reg != '0))
        else $error("lag recorded without average update");

    a_lag_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_data_reg[2]) |-> (out_data_reg[7:3] <= out_data_reg[12:8]))
        else $error("recorded lag above reported maximum");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for detection_lag_monitor: directed table, then regime runs with dips.
// Depends on dlm_pkg and the detection_lag_monitor RTL; predicts each untyped output word.

module tb_top
    import dlm_pkg::*;
();

    localparam int RING_DEPTH    = 16;
    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 229;
    localparam int DIR_ROWS      = 18;
    localparam logic [63:0] SAT48 = 64'h0000_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [4:0]  history_fill;
        logic [12:0] avg_lag;
        logic [15:0] violation_count;
        logic [4:0]  max_lag;
        logic [4:0]  lag_value;
        logic        lag_recorded;
        logic        regime_changed;
        logic        drop_active;
    } lag_report_t;

    localparam int REPORT_W = $bits(lag_report_t);

    typedef struct packed {
        bit          typed;
        lag_report_t want;
        logic [7:0]  label;
        logic [31:0] sample;
    } probe_row_t;

    typedef struct packed {
        logic [15:0] thr;
        logic [4:0]  lim;
        logic [4:0]  tmo;
        logic [15:0] fa;
        logic [15:0] sa;
    } monitor_setting_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [47:0]           m_axis_tdata;

    detection_lag_monitor #(.HIST_DEPTH(RING_DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor copy of the registers and tracker state
    logic [15:0] thr_q  = RST_DROP_THRESHOLD;
    logic [4:0]  lim_q  = RST_LAG_LIMIT;
    logic [4:0]  tmo_q  = RST_DROP_TIMEOUT;
    logic [15:0] fast_a = RST_FAST_ALPHA;
    logic [15:0] slow_a = RST_SLOW_ALPHA;

    longint      mean_q = 0;
    logic [63:0] sigma2 = '0;
    bit          fresh = 1'b1;
    bit          in_drop = 1'b0;
    bit          have_label = 1'b0;
    logic [4:0]  ticks = '0;
    logic [7:0]  prev_label = '0;
    logic [4:0]  ring_q [RING_DEPTH];
    logic [3:0]  ring_pos = '0;
    int          ring_fill = 0;
    int          ring_sum = 0;
    logic [4:0]  lag_max = '0;
    logic [15:0] viol = '0;
    logic [12:0] lag_avg = '0;

    lag_report_t pending_reports [$];
    lag_report_t got_rep, want_rep;
    int          fails = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;
    bit          idling_on = 1'b1;
    logic [7:0]  last_label = '0;

    // first item, lag 3 recorded, change with no open drop
    probe_row_t dir_rows [DIR_ROWS] = '{
        '{1'b1, '0, 8'h00, 32'h0000_0000},
        '{1'b0, '0, 8'h00, 32'h0000_0000},
        '{1'b0, '0, 8'h00, 32'h0000_0000},
        '{1'b0, '0, 8'h00, 32'hFFF6_0000},
        '{1'b0, '0, 8'h00, 32'hFFF6_0000},
        '{1'b1, '{5'd1, 13'd768, 16'd0, 5'd3, 5'd3, 1'b1, 1'b1, 1'b0}, 8'h01, 32'h0000_0000},
        '{1'b0, '0, 8'h01, 32'h0000_0000},
        '{1'b1, '{5'd1, 13'd768, 16'd0, 5'd3, 5'd0, 1'b0, 1'b1, 1'b0}, 8'h02, 32'h0000_0000},
        '{1'b0, '0, 8'h02, 32'h7FFF_FFFF},
        '{1'b0, '0, 8'h02, 32'h8000_0000},
        '{1'b0, '0, 8'h02, 32'h8000_0000},
        '{1'b0, '0, 8'hFF, 32'h7FFF_FFFF},
        '{1'b0, '0, 8'hFF, 32'h8000_0000},
        '{1'b0, '0, 8'hFF, 32'h0000_0001},
        '{1'b0, '0, 8'hFF, 32'hFFFF_FFFF},
        '{1'b0, '0, 8'h80, 32'h0000_0000},
        '{1'b0, '0, 8'h80, 32'h5555_5555},
        '{1'b0, '0, 8'h7F, 32'hAAAA_AAAA}
    };

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic lag_report_t predict_lag_report(input logic [31:0] sample,
                                                       input logic [7:0] label);
        longint      x;
        longint      dev;
        longint      surprise;
        logic [63:0] ad;
        logic [63:0] sq;
        logic [63:0] su;
        logic [63:0] bound;
        logic [127:0] prod;
        logic [4:0]  lag;
        bit          chg;
        bit          rec;
        lag_report_t r;

        x = longint'($signed(sample));
        lag = '0;
        rec = 1'b0;
        if (fresh) begin
            mean_q = x;
            sigma2 = 64'(VAR_SEED);
        end
        else begin
            dev = x - mean_q;
            ad = (dev < 0) ? -dev : dev;
            if (ad >= 64'h1_0000_0000) sq = SAT48;
            else begin
                sq = (ad * ad) >> 16;
                if (sq > SAT48) sq = SAT48;
            end
            mean_q = mean_q + (dev * longint'({48'd0, fast_a})) / longint'(65536);
            if (sq >= sigma2) sigma2 = sigma2 + (((sq - sigma2) * {48'd0, slow_a}) >> 16);
            else sigma2 = sigma2 - (((sigma2 - sq) * {48'd0, slow_a}) >> 16);
        end

        surprise = mean_q - x;
        if (surprise > 0 && !in_drop) begin
            su = surprise;
            prod = {112'd0, thr_q} * {112'd0, thr_q};
            prod = prod * {64'd0, sigma2};
            bound = (prod[127:64] != '0) ? '1 : prod[63:0];
            if (su * su > bound) begin
                in_drop = 1'b1;
                ticks = '0;
            end
        end
        if (in_drop && ticks < 5'd31) ticks = ticks + 5'd1;

        chg = have_label && (label != prev_label);
        if (chg) begin
            if (in_drop) begin
                lag = ticks;
                rec = 1'b1;
                if (ring_fill >= RING_DEPTH) ring_sum = ring_sum - ring_q[ring_pos];
                else ring_fill = ring_fill + 1;
                ring_q[ring_pos] = lag;
                ring_sum = ring_sum + lag;
                ring_pos = ring_pos + 4'd1;
                if (lag > lag_max) lag_max = lag;
                if (lag > lim_q && viol != 16'hFFFF) viol = viol + 16'd1;
                lag_avg = 13'((ring_sum * 256) / ring_fill);
                in_drop = 1'b0;
            end
            fresh = 1'b1;
        end
        else fresh = 1'b0;
        prev_label = label;
        have_label = 1'b1;

        if (in_drop && ticks > tmo_q) in_drop = 1'b0;

        r.drop_active     = in_drop;
        r.regime_changed  = chg;
        r.lag_recorded    = rec;
        r.lag_value       = lag;
        r.max_lag         = lag_max;
        r.violation_count = viol;
        r.avg_lag         = lag_avg;
        r.history_fill    = 5'(ring_fill);
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    task automatic send_word(input logic [31:0] sample, input logic [7:0] label,
                             input bit typed, input lag_report_t typed_want);
        lag_report_t pred;
        int          n;

        @(negedge clk);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            n = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {label, sample};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pred = predict_lag_report(sample, label);
        pending_reports.push_back(typed ? typed_want : pred);
        last_label = label;
    endtask

    task automatic wait_for_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_DROP_THRESHOLD: thr_q  = val;
            REG_LAG_LIMIT:      lim_q  = val[4:0];
            REG_DROP_TIMEOUT:   tmo_q  = val[4:0];
            REG_FAST_ALPHA:     fast_a = val;
            REG_SLOW_ALPHA:     slow_a = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 4))
            0, 1:    return 0;
            2:       return 10;
            3:       return 30;
            default: return 60;
        endcase
    endfunction

    // stable runs of one regime, often with a dip, then usually a label change
    task automatic run_regime_runs(input int budget);
        int          sent;
        int          len;
        int          dip_at;
        int          dip_len;
        int          k;
        longint      base;
        longint      amp;
        longint      depth;
        logic [7:0]  nxt;

        sent = 0;
        while (sent < budget) begin
            if (idling_on && $urandom_range(0, 3) == 0) begin
                gap_pct   = pick_pct();
                stall_pct = pick_pct();
            end
            if ($urandom_range(0, 9) == 0) begin
                send_word($urandom, 8'($urandom), 1'b0, '0);
                sent++;
            end
            else begin
                if ($urandom_range(0, 7) == 0) nxt = last_label;
                else nxt = last_label + 8'($urandom_range(1, 255));
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(2, 14);
                base    = longint'($urandom_range(0, 32'h40_0000)) - 64'sh20_0000;
                amp     = longint'(1) << $urandom_range(4, 14);
                depth   = longint'(1) << $urandom_range(14, 29);
                dip_at  = $urandom_range(1, len);
                dip_len = $urandom_range(1, 3);
                for (k = 0; k < len && sent < budget; k++) begin
                    if (k >= dip_at && k < dip_at + dip_len)
                        send_word(32'(base - depth), nxt, 1'b0, '0);
                    else
                        send_word(32'(base + longint'($urandom_range(0, 2 * amp)) - amp),
                                  nxt, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // output side back-pressure
    initial begin
        forever begin
            @(negedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got_rep = m_axis_tdata[REPORT_W-1:0];
            if (pending_reports.size() == 0) begin
                $error("result word with no pending expectation");
                fails++;
            end
            else begin
                want_rep = pending_reports.pop_front();
                check_field("drop_active", want_rep.drop_active, got_rep.drop_active);
                check_field("regime_changed", want_rep.regime_changed,
                            got_rep.regime_changed);
                check_field("lag_recorded", want_rep.lag_recorded, got_rep.lag_recorded);
                check_field("lag_value", want_rep.lag_value, got_rep.lag_value);
                check_field("max_lag", want_rep.max_lag, got_rep.max_lag);
                check_field("violation_count", want_rep.violation_count,
                            got_rep.violation_count);
                check_field("avg_lag", want_rep.avg_lag, got_rep.avg_lag);
                check_field("history_fill", want_rep.history_fill, got_rep.history_fill);
            end
        end
    end

    // watchdog: consecutive cycles with no handshake on any channel
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        int               i;
        int               ph;
        monitor_setting_t cfg_set;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        gap_pct   = 20;
        stall_pct = 20;
        for (i = 0; i < DIR_ROWS; i++)
            send_word(dir_rows[i].sample, dir_rows[i].label, dir_rows[i].typed,
                      dir_rows[i].want);

        for (ph = 0; ph < PHASES; ph++) begin
            wait_for_idle();
            case (ph)
                0: cfg_set = '{16'd0, 5'd0, 5'd0, 16'hFFFF, 16'hFFFF};
                1: cfg_set = '{16'hFFFF, 5'd31, 5'd31, 16'd0, 16'd0};
                2: cfg_set = '{16'd256, 5'd3, 5'd31, RST_FAST_ALPHA, RST_SLOW_ALPHA};
                3: cfg_set = '{16'd768, 5'd10, 5'd30, 16'd16384, 16'd4096};
                PHASES - 1: cfg_set = '{RST_DROP_THRESHOLD, RST_LAG_LIMIT, RST_DROP_TIMEOUT,
                                        RST_FAST_ALPHA, RST_SLOW_ALPHA};
                default: cfg_set = '{16'($urandom_range(64, 2048)), 5'($urandom),
                                     5'($urandom), 16'($urandom_range(1, 65535)),
                                     16'($urandom)};
            endcase
            write_reg(REG_DROP_THRESHOLD, cfg_set.thr);
            write_reg(REG_LAG_LIMIT, {11'($urandom), cfg_set.lim});
            write_reg(REG_DROP_TIMEOUT, {11'($urandom), cfg_set.tmo});
            write_reg(REG_FAST_ALPHA, cfg_set.fa);
            write_reg(REG_SLOW_ALPHA, cfg_set.sa);
            if (ph % 2 == 0)
                write_reg(REG_SLOW_ALPHA + 3'd1 + 3'($urandom_range(0, 2)), 16'($urandom));

            if (ph == PHASES - 1) begin
                idling_on = 1'b0;
                gap_pct   = 0;
                stall_pct = 0;
            end
            run_regime_runs(PHASE_WORDS);
        end

        wait_for_idle();
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
